// File: rtl/core/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared widths, microcode word layout and control program for the
// trial-division prime test.
// ----------------------------------------------------------------------------
package tdp_pkg;

  // Width of the tested value, taken from the low bits of the request.
  localparam int VALUE_BITS = 32;
  localparam int SQ_BITS    = VALUE_BITS + 1;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
  localparam int PC_BITS    = 4;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [SQ_BITS-1:0]    square_t;
  typedef logic [PC_BITS-1:0]    pc_t;

  // Datapath action of one step.
  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_DIV_START,
    A_NEXT_DIV,
    A_DONE_PRIME,
    A_DONE_COMPOSITE
  } act_t;

  // Branch condition of one step; the step falls through when false.
  typedef enum logic [2:0] {
    C_REM_ZERO,
    C_ALWAYS,
    C_NO_START,
    C_SMALL,
    C_TWO,
    C_EVEN,
    C_SQ_GT,
    C_DIV_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Status from the remainder unit.
  typedef struct packed {
    logic busy;
    logic rem_zero;
  } rem_stat_t;

  // Program addresses.
  localparam pc_t S_IDLE   = 4'd0;
  localparam pc_t S_SMALL  = 4'd1;
  localparam pc_t S_TWO    = 4'd2;
  localparam pc_t S_EVEN   = 4'd3;
  localparam pc_t S_BOUND  = 4'd4;
  localparam pc_t S_DIV    = 4'd5;
  localparam pc_t S_WAIT   = 4'd6;
  localparam pc_t S_REM    = 4'd7;
  localparam pc_t S_STEP   = 4'd8;
  localparam pc_t S_PASS   = 4'd9;
  localparam pc_t S_FAIL   = 4'd10;

  // Control store.
  function automatic uword_t ucode_fetch(input pc_t pc);
    uword_t w;
    unique case (pc)
      S_IDLE:  w = '{act: A_LOAD,           cond: C_NO_START, target: S_IDLE};
      S_SMALL: w = '{act: A_NONE,           cond: C_SMALL,    target: S_FAIL};
      S_TWO:   w = '{act: A_NONE,           cond: C_TWO,      target: S_PASS};
      S_EVEN:  w = '{act: A_NONE,           cond: C_EVEN,     target: S_FAIL};
      S_BOUND: w = '{act: A_NONE,           cond: C_SQ_GT,    target: S_PASS};
      S_DIV:   w = '{act: A_DIV_START,      cond: C_ALWAYS,   target: S_WAIT};
      S_WAIT:  w = '{act: A_NONE,           cond: C_DIV_BUSY, target: S_WAIT};
      S_REM:   w = '{act: A_NONE,           cond: C_REM_ZERO, target: S_FAIL};
      S_STEP:  w = '{act: A_NEXT_DIV,       cond: C_ALWAYS,   target: S_BOUND};
      S_PASS:  w = '{act: A_DONE_PRIME,     cond: C_ALWAYS,   target: S_IDLE};
      S_FAIL:  w = '{act: A_DONE_COMPOSITE, cond: C_ALWAYS,   target: S_IDLE};
      default: w = '{act: A_NONE,           cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/tdp_rem_unit.sv
// ----------------------------------------------------------------------------
// tdp_rem_unit
// Restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdp_rem_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tdp_pkg::value_t    dividend,
  input  tdp_pkg::value_t    divisor,
  output tdp_pkg::rem_stat_t stat
);
  import tdp_pkg::*;

  logic                busy;
  logic [CNT_BITS-1:0] count;
  value_t              dvd;
  value_t              dsr;
  square_t             rem;
  square_t             rem_shift;
  square_t             rem_next;

  // One restoring step: shift in next dividend bit, subtract if it fits.
  always_comb begin
    rem_shift = {rem[VALUE_BITS-1:0], dvd[VALUE_BITS-1]};
    if (rem_shift >= {1'b0, dsr}) begin
      rem_next = rem_shift - {1'b0, dsr};
    end else begin
      rem_next = rem_shift;
    end
  end

  // Control and operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_BITS'(VALUE_BITS);
    end else if (busy) begin
      count <= count - CNT_BITS'(1);
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Payload; no reset needed.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign stat.busy     = busy;
  assign stat.rem_zero = (rem == '0);

endmodule

// File: rtl/core/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by odd trial divisors, run by a small microcoded sequencer.
//
//   channel   signals                 direction  notes
//   request   start, candidate[31:0]  in         taken when start && !busy
//   result    done, prime_flag        out        one-cycle strobe, no stall
//
// Values below 2 or with bit 31 set, the value 2 and even values are settled
// without trial division. Odd values run one remainder operation per odd
// divisor tried, from 3 upward, until the divisor's square exceeds the value
// or a divisor leaves no remainder; the bit-serial remainder unit sets the
// time taken per divisor.
// busy is high from the cycle after acceptance until the result strobe.
// Reset is synchronous and returns the sequencer to idle.
// The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] candidate,
  output logic        busy,
  output logic        done,
  output logic        prime_flag
);
  import tdp_pkg::*;

  pc_t       pc;
  pc_t       pc_next;
  uword_t    uw;
  logic      take;
  value_t    value;
  value_t    divisor;
  square_t   square;
  value_t    cand_low;
  logic [63:0] cand_ext;
  rem_stat_t rstat;
  logic      cond_true;
  logic      f_small;
  logic      f_two;
  logic      f_even;
  logic      f_sq_gt;

  assign cand_ext = {{32{candidate[31]}}, candidate};
  assign cand_low = cand_ext[VALUE_BITS-1:0];
  assign take     = start && !busy;
  assign busy     = (pc != S_IDLE);
  assign uw       = ucode_fetch(pc);

  // Datapath flags.
  assign f_small = value[VALUE_BITS-1] || (value < VALUE_BITS'(2));
  assign f_two   = (value == VALUE_BITS'(2));
  assign f_sq_gt = (square > {1'b0, value});
  assign f_even  = !value[0];

  // Branch condition decode.
  always_comb begin
    unique case (uw.cond)
      C_REM_ZERO: cond_true = rstat.rem_zero;
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_START: cond_true = !start;
      C_SMALL:    cond_true = f_small;
      C_TWO:      cond_true = f_two;
      C_EVEN:     cond_true = f_even;
      C_SQ_GT:    cond_true = f_sq_gt;
      C_DIV_BUSY: cond_true = rstat.busy;
      default:    cond_true = 1'b1;
    endcase
    pc_next = cond_true ? uw.target : pc + PC_BITS'(1);
  end

  // Step counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= S_IDLE;
      done <= 1'b0;
    end else begin
      pc   <= pc_next;
      done <= (uw.act == A_DONE_PRIME) || (uw.act == A_DONE_COMPOSITE);
    end
  end

  // Value, divisor, running square of the divisor and result flag.
  always_ff @(posedge clk) begin
    case (uw.act)
      A_LOAD: begin
        if (take) begin
          value   <= cand_low;
          divisor <= VALUE_BITS'(3);
          square  <= SQ_BITS'(9);
        end
      end
      A_NEXT_DIV: begin
        // (d + 2)^2 = d^2 + 4d + 4
        divisor <= divisor + VALUE_BITS'(2);
        square  <= square + (SQ_BITS'(divisor) << 2) + SQ_BITS'(4);
      end
      A_DONE_PRIME:     prime_flag <= 1'b1;
      A_DONE_COMPOSITE: prime_flag <= 1'b0;
      default: ;
    endcase
  end

  tdp_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (uw.act == A_DIV_START),
    .dividend (value),
    .divisor  (divisor),
    .stat     (rstat)
  );

  // Checks.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_take_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_rem_in_wait: assert property (@(posedge clk) disable iff (rst)
    rstat.busy |-> (pc == S_WAIT))
    else $error("remainder unit running outside the wait step");

endmodule
